[rtl/s2x_pkg.sv]
// Shared types, constants and pixel functions for the Scale2x upscaler.
`default_nettype none

package s2x_pkg;

  // Geometry of the line stores and the position counters.
  localparam int unsigned MaxWidth = 512;
  localparam int unsigned MaxLines = 1024;
  localparam int unsigned AddrW    = $clog2(MaxWidth);
  localparam int unsigned RowW     = $clog2(MaxLines);
  localparam int unsigned WidthW   = 10;
  localparam int unsigned PixW     = 16;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] REG_LINE_WIDTH    = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SCANLINE_MODE = 1'd1;

  localparam logic [WidthW-1:0] LINE_WIDTH_RST = 10'd322;
  localparam logic [WidthW-1:0] WIDTH_MIN      = 10'd3;
  localparam logic [WidthW-1:0] WIDTH_MAX      = WidthW'(MaxWidth);
  localparam logic [RowW-1:0]   ROW_LAST       = RowW'(MaxLines - 1);

  // Per-channel halving mask for RGB565 (drops the LSB of each channel).
  localparam logic [PixW-1:0] HALF_MASK = 16'hf7de;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutBits  = 4 * PixW + AddrW + RowW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  typedef enum logic [1:0] {
    SCAN_PLAIN   = 2'd0,
    SCAN_HALF    = 2'd1,
    SCAN_THREE_Q = 2'd2
  } scan_mode_e;

  // Neighborhood of one center pixel.
  typedef struct packed {
    logic [PixW-1:0] above;
    logic [PixW-1:0] left;
    logic [PixW-1:0] right;
    logic [PixW-1:0] below;
    logic [PixW-1:0] center;
  } nbr_t;

  // One 2x2 output block.
  typedef struct packed {
    logic [PixW-1:0] top_left;
    logic [PixW-1:0] top_right;
    logic [PixW-1:0] bottom_left;
    logic [PixW-1:0] bottom_right;
  } blk_t;

  // A corner takes the edge neighbor when its side matches the edge and
  // both the opposite neighbor and the other side differ from it.
  function automatic logic [PixW-1:0] pick_corner(
    input logic [PixW-1:0] side,
    input logic [PixW-1:0] other,
    input logic [PixW-1:0] edge_px,
    input logic [PixW-1:0] opp,
    input logic [PixW-1:0] center
  );
    logic take;
    take = (side == edge_px) && (opp != edge_px) && (other != edge_px);
    return take ? edge_px : center;
  endfunction

  // Scanline dimming of a bottom output pixel.
  function automatic logic [PixW-1:0] dim_pixel(
    input logic [1:0]      mode,
    input logic [PixW-1:0] p
  );
    logic [PixW-1:0] half;
    logic [PixW-1:0] res;
    half = (p & HALF_MASK) >> 1;
    unique case (mode)
      SCAN_HALF:    res = half;
      SCAN_THREE_Q: res = half + ((half & HALF_MASK) >> 1);
      default:      res = p;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/s2x_line_store.sv]
// Two source line memories with registered, read-first read ports.
`default_nettype none

module s2x_line_store
  import s2x_pkg::*;
(
  input  wire logic             clk_i,
  // Middle line: one write and a read at the arriving column, and a read at the next column.
  input  wire logic             mid_en_i,
  input  wire logic [AddrW-1:0] mid_addr_i,
  input  wire logic [AddrW-1:0] mid_next_addr_i,
  input  wire logic [PixW-1:0]  mid_wdata_i,
  output logic      [PixW-1:0]  mid_rdata_o,
  output logic      [PixW-1:0]  mid_next_rdata_o,
  // Upper line: read with the middle line, written afterwards with the displaced middle value.
  input  wire logic             up_we_i,
  input  wire logic [AddrW-1:0] up_waddr_i,
  input  wire logic [PixW-1:0]  up_wdata_i,
  output logic      [PixW-1:0]  up_rdata_o
);

  logic [PixW-1:0] mid_mem [MaxWidth];
  logic [PixW-1:0] up_mem  [MaxWidth];

  // Middle line: reads return the contents before this cycle's write.
  always_ff @(posedge clk_i) begin
    if (mid_en_i) begin
      mid_rdata_o              <= mid_mem[mid_addr_i];
      mid_next_rdata_o         <= mid_mem[mid_next_addr_i];
      mid_mem[mid_addr_i]      <= mid_wdata_i;
    end
  end

  // Upper line read, enabled together with the middle line read.
  always_ff @(posedge clk_i) begin
    if (mid_en_i) begin
      up_rdata_o <= up_mem[mid_addr_i];
    end
  end

  // Upper line write of the displaced middle value.
  always_ff @(posedge clk_i) begin
    if (up_we_i) begin
      up_mem[up_waddr_i] <= up_wdata_i;
    end
  end

endmodule

`default_nettype wire

[rtl/s2x_kernel.sv]
// Scale2x corner selection and scanline dimming for one center pixel.
`default_nettype none

module s2x_kernel
  import s2x_pkg::*;
(
  input  wire nbr_t       nbr_i,
  input  wire logic [1:0] mode_i,
  output blk_t            blk_o
);

  logic [PixW-1:0] bl_raw;
  logic [PixW-1:0] br_raw;

  // Top corners look up, bottom corners look down.
  always_comb begin
    blk_o.top_left  = pick_corner(nbr_i.left,  nbr_i.right, nbr_i.above,
                                  nbr_i.below, nbr_i.center);
    blk_o.top_right = pick_corner(nbr_i.right, nbr_i.left,  nbr_i.above,
                                  nbr_i.below, nbr_i.center);
    bl_raw          = pick_corner(nbr_i.left,  nbr_i.right, nbr_i.below,
                                  nbr_i.above, nbr_i.center);
    br_raw          = pick_corner(nbr_i.right, nbr_i.left,  nbr_i.below,
                                  nbr_i.above, nbr_i.center);
    blk_o.bottom_left  = dim_pixel(mode_i, bl_raw);
    blk_o.bottom_right = dim_pixel(mode_i, br_raw);
  end

endmodule

`default_nettype wire

[rtl/scale2x_pixel_upscaler_unit.sv]
// Top level of the Scale2x pixel-art upscaler stream block.
`default_nettype none

// Takes one RGB565 source pixel per clock in raster order (tuser marks the
// first pixel of a frame) and, for each pixel on row 2 or later at an
// interior column, delivers the 2x2 Scale2x block of the pixel above it,
// together with that pixel's interior column and row. A request is taken
// every cycle while the output side keeps up; each request passes through
// the synchronous read of the two line memories into the read stage and
// then corner selection into the output register. The line memories need
// no clearing after reset. line_width and scanline_mode may only be
// written while the block is idle.
module scale2x_pixel_upscaler_unit
  import s2x_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port.
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // Source pixel stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [15:0] pixel
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [0] frame_start
  input  wire logic                s_axis_tuser,
  // Output block stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [15:0] out_top_left, [31:16] out_top_right, [47:32] out_bottom_left,
  // [63:48] out_bottom_right, [72:64] out_col, [82:73] out_row, rest zero
  output logic [OutDataW-1:0]      m_axis_tdata
);

  // Configuration registers.
  logic [WidthW-1:0] width_q;
  logic [1:0]        mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= LINE_WIDTH_RST;
      mode_q  <= SCAN_PLAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LINE_WIDTH:    width_q <= cfg_data_i;
        REG_SCANLINE_MODE: mode_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Effective width, clamped to the supported range.
  logic [WidthW-1:0] eff_w;
  always_comb begin
    priority if (width_q < WIDTH_MIN) eff_w = WIDTH_MIN;
    else if (width_q > WIDTH_MAX)     eff_w = WIDTH_MAX;
    else                              eff_w = width_q;
  end

  // Position of the arriving pixel.
  logic             accept;
  logic [AddrW-1:0] col_q, col_d, cur_col;
  logic [RowW-1:0]  row_q, row_d, cur_row;
  logic [WidthW-1:0] col_ext;
  logic             cur_emit;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign cur_col = s_axis_tuser ? '0 : col_q;
  assign cur_row = s_axis_tuser ? '0 : row_q;
  assign col_ext = WidthW'(cur_col);
  assign cur_emit = (cur_row >= RowW'(2)) && (cur_col != '0) &&
                    ((col_ext + WidthW'(2)) <= eff_w);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if ((col_ext + WidthW'(1)) >= eff_w) begin
        col_d = '0;
        row_d = (cur_row < ROW_LAST) ? cur_row + RowW'(1) : cur_row;
      end else begin
        col_d = cur_col + AddrW'(1);
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Read stage: item whose memory reads are in flight.
  logic             s1_valid_q;
  logic             s1_emit_q;
  logic [AddrW-1:0] s1_col_q;
  logic [RowW-1:0]  s1_row_q;
  logic [PixW-1:0]  s1_px_q;
  logic             fwd_q;
  logic [PixW-1:0]  fwd_px_q;
  logic [PixW-1:0]  left_q;
  logic             s1_adv;
  logic             out_valid_q;

  logic [PixW-1:0] mid_rdata, mid_next_rdata, up_rdata;

  // The line store writes the upper line for the item in the read stage;
  // a following item at the same column takes that value from the bypass.
  s2x_line_store u_store (
    .clk_i            (clk_i),
    .mid_en_i         (accept),
    .mid_addr_i       (cur_col),
    .mid_next_addr_i  (cur_col + AddrW'(1)),
    .mid_wdata_i      (s_axis_tdata[PixW-1:0]),
    .mid_rdata_o      (mid_rdata),
    .mid_next_rdata_o (mid_next_rdata),
    .up_we_i          (s1_valid_q),
    .up_waddr_i       (s1_col_q),
    .up_wdata_i       (mid_rdata),
    .up_rdata_o       (up_rdata)
  );

  assign s1_adv        = s1_valid_q && (!s1_emit_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Payload of the read stage, and the upper-line bypass.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q <= cur_emit;
      s1_col_q  <= cur_col;
      s1_row_q  <= cur_row - RowW'(2);
      s1_px_q   <= s_axis_tdata[PixW-1:0];
      fwd_q     <= s1_valid_q && (s1_col_q == cur_col);
      fwd_px_q  <= mid_rdata;
    end
  end

  // Left neighbor: displaced middle value of the previous column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (s1_adv) begin
      left_q <= mid_rdata;
    end
  end

  // Corner selection.
  nbr_t nbr;
  blk_t blk;

  assign nbr.above  = fwd_q ? fwd_px_q : up_rdata;
  assign nbr.left   = left_q;
  assign nbr.right  = mid_next_rdata;
  assign nbr.below  = s1_px_q;
  assign nbr.center = mid_rdata;

  s2x_kernel u_kernel (
    .nbr_i  (nbr),
    .mode_i (mode_q),
    .blk_o  (blk)
  );

  // Output register.
  logic             load_out;
  blk_t             out_blk_q;
  logic [AddrW-1:0] out_col_q;
  logic [RowW-1:0]  out_row_q;

  assign load_out = s1_adv && s1_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_blk_q <= blk;
      out_col_q <= s1_col_q - AddrW'(1);
      out_row_q <= s1_row_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_row_q, out_col_q,
                                    out_blk_q.bottom_right, out_blk_q.bottom_left,
                                    out_blk_q.top_right, out_blk_q.top_left});

endmodule

`default_nettype wire
